// ----- rtl/sdip_pkg.sv -----
`default_nettype none

package sdip_pkg;

    // Character codes that the parser treats specially.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Digit count only needs to tell none, one and more than one apart.
    localparam logic [1:0] DIG_NONE = 2'd0;
    localparam logic [1:0] DIG_ONE  = 2'd1;
    localparam logic [1:0] DIG_MANY = 2'd2;

    // One character item after the input register.
    typedef struct packed {
        logic [7:0] char_code;
        logic       no_char;
        logic       last;
    } t_item;

    // Snapshot of a finished string, handed to the finishing stage.
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        logic        good;
    } t_fin;

endpackage

`default_nettype wire

// ----- rtl/sdip_accum.sv -----
`default_nettype none

module sdip_accum
    import sdip_pkg::*;
#(
    parameter int MAX_CHARS = 20
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_take,
    input  t_item i_item,
    input  wire  i_fin_pop,
    output logic o_fin_vld,
    output t_fin o_fin
);

    localparam int CW = $clog2(MAX_CHARS + 1);

    logic [63:0]   r_mag,   n_mag;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic          r_neg,   n_neg;
    logic          r_fz,    n_fz;
    logic [1:0]    r_dcnt,  n_dcnt;
    logic          r_fail,  n_fail;
    logic          r_fin_vld;
    t_fin          r_fin;

    logic [3:0]  digit;
    logic [67:0] sum;
    logic        is_digit;
    logic        is_sign;
    logic        good_pre;

    assign digit    = i_item.char_code[3:0];
    assign is_digit = (i_item.char_code >= CH_ZERO) && (i_item.char_code <= CH_NINE);
    assign is_sign  = (i_item.char_code == CH_PLUS) || (i_item.char_code == CH_MINUS);
    // Times ten as two shifted copies, plus the new digit; overflow shows in the top bits.
    assign sum = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) + {64'd0, digit};

    always_comb begin
        n_mag  = r_mag;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_fz   = r_fz;
        n_dcnt = r_dcnt;
        n_fail = r_fail;
        if (!i_item.no_char) begin
            if (r_cnt >= CW'(MAX_CHARS)) begin
                n_fail = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
                if ((r_cnt == '0) && is_sign) begin
                    n_neg = (i_item.char_code == CH_MINUS);
                end else if (!is_digit) begin
                    n_fail = 1'b1;
                end else begin
                    if (r_dcnt == DIG_NONE) begin
                        n_fz = (digit == 4'd0);
                    end
                    if (r_dcnt != DIG_MANY) begin
                        n_dcnt = r_dcnt + 1'b1;
                    end
                    if (!r_fail) begin
                        if (|sum[67:64]) begin
                            n_fail = 1'b1;
                        end else begin
                            n_mag = sum[63:0];
                        end
                    end
                end
            end
        end
        good_pre = !n_fail && (n_dcnt != DIG_NONE) && !((n_dcnt == DIG_MANY) && n_fz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag  <= '0;
            r_cnt  <= '0;
            r_neg  <= 1'b0;
            r_fz   <= 1'b0;
            r_dcnt <= DIG_NONE;
            r_fail <= 1'b0;
        end else if (i_take) begin
            if (i_item.last) begin
                r_mag  <= '0;
                r_cnt  <= '0;
                r_neg  <= 1'b0;
                r_fz   <= 1'b0;
                r_dcnt <= DIG_NONE;
                r_fail <= 1'b0;
            end else begin
                r_mag  <= n_mag;
                r_cnt  <= n_cnt;
                r_neg  <= n_neg;
                r_fz   <= n_fz;
                r_dcnt <= n_dcnt;
                r_fail <= n_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (i_take && i_item.last) begin
            r_fin_vld <= 1'b1;
        end else if (i_fin_pop) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_item.last) begin
            r_fin.mag  <= n_mag;
            r_fin.neg  <= n_neg;
            r_fin.good <= good_pre;
        end
    end

    assign o_fin_vld = r_fin_vld;
    assign o_fin     = r_fin;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_CHARS))
        else $error("character count beyond limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.last |=> (r_cnt == '0) && (r_mag == '0) && !r_fail)
        else $error("state not cleared after end of string");

    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_vld && !i_fin_pop |=> r_fin_vld && $stable(r_fin))
        else $error("finished string lost before it moved on");
`endif

endmodule

`default_nettype wire

// ----- rtl/sdip_final.sv -----
`default_nettype none

module sdip_final
    import sdip_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_fin_vld,
    input  t_fin        i_fin,
    input  wire         i_ready,
    output logic        o_fin_pop,
    output logic        o_vld,
    output logic [63:0] o_value,
    output logic        o_ok
);

    logic        r_vld;
    logic [63:0] r_value;
    logic        r_ok;
    logic        ok;
    logic [63:0] value;

    // A negative magnitude may reach 2^63 exactly; a positive one must stay below it.
    always_comb begin
        if (i_fin.neg) begin
            ok = i_fin.good && !(i_fin.mag[63] && (|i_fin.mag[62:0]));
        end else begin
            ok = i_fin.good && !i_fin.mag[63];
        end
        if (!ok) begin
            value = '0;
        end else if (i_fin.neg) begin
            value = 64'd0 - i_fin.mag;
        end else begin
            value = i_fin.mag;
        end
    end

    assign o_fin_pop = i_fin_vld && (!r_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_fin_pop) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_pop) begin
            r_value <= value;
            r_ok    <= ok;
        end
    end

    assign o_vld   = r_vld;
    assign o_value = r_value;
    assign o_ok    = r_ok;

`ifndef ASSERT_OFF
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_ok |-> r_value == '0)
        else $error("rejected string gives nonzero value");
`endif

endmodule

`default_nettype wire

// ----- rtl/strict_decimal_int64_parser.sv -----
// Channel   Direction  Ports                          Contents
// s_axis    in         tvalid tready tdata tuser tlast one character byte per transfer
// m_axis    out        tvalid tready tdata tuser      one result per finished string
//
// The block takes one character transfer per cycle while the result path does
// not stall; the rate is set by the combinational multiply-by-ten-and-add
// step of the accumulator. The transfer carrying tlast passes through the
// input register, the finished-string register and the output register, in
// that order, before its result becomes valid.
// Reset is synchronous and active low; it drops all valid flags and clears
// the accumulator. A stalled result holds the output and, once the internal
// registers fill, deasserts the input tready.
`default_nettype none

module strict_decimal_int64_parser
    import sdip_pkg::*;
#(
    parameter int MAX_CHARS = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  wire         i_s_axis_tuser,   // [0] no_char
    input  wire         i_s_axis_tlast,   // last item of the string
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] result_value (signed)
    output logic        o_m_axis_tuser    // [0] ok
);

    // Input register: one character waits here while the accumulator decides
    // whether it can be taken this cycle.
    logic  r_in_vld;
    t_item r_in;
    logic  take;
    logic  fin_vld;
    logic  fin_pop;
    t_fin  fin;

    // A character that does not end the string can always be taken; the last
    // one needs room in the finished-string register.
    assign take            = r_in_vld && (!r_in.last || !fin_vld || fin_pop);
    assign o_s_axis_tready = !r_in_vld || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in.char_code <= i_s_axis_tdata;
            r_in.no_char   <= i_s_axis_tuser;
            r_in.last      <= i_s_axis_tlast;
        end
    end

    sdip_accum #(
        .MAX_CHARS (MAX_CHARS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_item    (r_in),
        .i_fin_pop (fin_pop),
        .o_fin_vld (fin_vld),
        .o_fin     (fin)
    );

    // Range check, sign and the output register.
    sdip_final u_final (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fin_vld (fin_vld),
        .i_fin     (fin),
        .i_ready   (i_m_axis_tready),
        .o_fin_pop (fin_pop),
        .o_vld     (o_m_axis_tvalid),
        .o_value   (o_m_axis_tdata),
        .o_ok      (o_m_axis_tuser)
    );

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> o_s_axis_tready)
        else $error("input stalled with an empty input register");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_strict_decimal_int64_parser.sv -----
`timescale 1ns / 1ps

module tb_strict_decimal_int64_parser;
    import sdip_pkg::*;

    localparam int          STR_MAX_CHARS = 20;
    localparam logic [63:0] MAG_ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] POS_LIMIT     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT     = 64'h8000_0000_0000_0000;
    localparam int          TAIL_CYCLES   = 12;
    localparam int          RANDOM_ITEMS  = 180;

    typedef struct {
        logic [63:0] value;
        logic        ok;
    } t_parse_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_valid;
    logic [7:0]  s_data;
    logic        s_user;
    logic        s_last;
    logic        m_ready;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [63:0] o_m_axis_tdata;
    wire         o_m_axis_tuser;

    always #6 i_clk = ~i_clk;

    strict_decimal_int64_parser #(
        .MAX_CHARS(STR_MAX_CHARS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),     // [7:0] char_code
        .i_s_axis_tuser (s_user),     // [0] no_char
        .i_s_axis_tlast (s_last),     // last item of the string
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),  // [63:0] result_value (signed)
        .o_m_axis_tuser (o_m_axis_tuser)   // [0] ok
    );

    // Parser state as the testbench tracks it, one string at a time.
    logic [63:0] acc_mag;
    int          n_chars;
    logic        neg_sign;
    logic        zero_first;
    int          n_digits;
    logic        str_bad;

    t_parse_result pending_results[$];
    logic [7:0]    str_buf[$];

    int  error_count    = 0;
    int  items_sent     = 0;
    int  strings_sent   = 0;
    int  values_ok      = 0;
    int  values_refused = 0;
    int  rx_hold_req    = 0;
    bit  tx_calm        = 1'b0;
    bit  rx_calm        = 1'b0;
    int  noise_rate     = 0;   // one no-character filler transfer in this many, 0 for none

    function automatic void clear_parse_state();
        acc_mag    = '0;
        n_chars    = 0;
        neg_sign   = 1'b0;
        zero_first = 1'b0;
        n_digits   = 0;
        str_bad    = 1'b0;
    endfunction

    // One character of the string. Once the string is bad, characters still
    // count toward the length but the magnitude is frozen.
    function automatic void parse_char(input logic [7:0] c);
        int          pos;
        logic [63:0] d;
        pos = n_chars;
        if (n_chars >= STR_MAX_CHARS) begin
            str_bad = 1'b1;
            return;
        end
        n_chars = n_chars + 1;
        if (pos == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
            neg_sign = (c == CH_MINUS);
            return;
        end
        if (c < CH_ZERO || c > CH_NINE) begin
            str_bad = 1'b1;
            return;
        end
        d = c - CH_ZERO;
        if (n_digits == 0)
            zero_first = (d == 0);
        if (n_digits < 31)
            n_digits = n_digits + 1;
        if (!str_bad) begin
            if (acc_mag > (MAG_ALL_ONES - d) / 10)
                str_bad = 1'b1;
            else
                acc_mag = acc_mag * 10 + d;
        end
    endfunction

    // End of string: decide the value and queue it for the result checker.
    function automatic void close_string();
        t_parse_result r;
        r.ok    = !str_bad && n_digits != 0;
        r.value = '0;
        if (r.ok && n_digits > 1 && zero_first)
            r.ok = 1'b0;
        if (r.ok) begin
            if (neg_sign) begin
                if (acc_mag > NEG_LIMIT)
                    r.ok = 1'b0;
                else
                    r.value = 64'd0 - acc_mag;
            end else begin
                if (acc_mag > POS_LIMIT)
                    r.ok = 1'b0;
                else
                    r.value = acc_mag;
            end
        end
        if (!r.ok)
            r.value = '0;
        pending_results.push_back(r);
        clear_parse_state();
    endfunction

    // Offers one transfer after a random gap and waits until it is taken.
    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_item(input logic [7:0] code, input logic nc, input logic lst);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data  <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= code;
        s_user  <= nc;
        s_last  <= lst;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (!nc)
            parse_char(code);
        if (lst)
            close_string();
        if (!nc || lst)
            items_sent = items_sent + 1;
    endtask

    // Sends the characters in str_buf as one string. When end_by_flag is set,
    // the string is closed by a separate no-character transfer with tlast.
    task automatic send_string(input bit end_by_flag);
        int n;
        n = str_buf.size();
        if (n == 0)
            end_by_flag = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (noise_rate != 0 && $urandom_range(1, noise_rate) == 1)
                send_item(8'($urandom), 1'b1, 1'b0);
            send_item(str_buf[i], 1'b0, !end_by_flag && i == n - 1);
        end
        if (end_by_flag)
            send_item(8'($urandom), 1'b1, 1'b1);
        strings_sent = strings_sent + 1;
    endtask

    task automatic send_text(input string t);
        str_buf.delete();
        for (int i = 0; i < t.len(); i++)
            str_buf.push_back(t[i]);
        send_string(1'b0);
    endtask

    // Stops offering and waits until every queued result has been checked.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_digits(input int count, input bit nonzero_first);
        for (int i = 0; i < count; i++) begin
            if (i == 0 && nonzero_first)
                str_buf.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            else
                str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic push_sign();
        case ($urandom_range(0, 2))
            0: ;
            1: str_buf.push_back(CH_PLUS);
            default: str_buf.push_back(CH_MINUS);
        endcase
    endtask

    // Small values, zero unsigned and with a minus sign, and the empty and sign-only strings.
    task automatic test_basic_values();
        send_text("0");
        send_text("7");
        send_text("-0");
        send_text("+9");
        send_text("-42");
        send_text("");
        send_text("+");
        send_text("-");
    endtask

    // Both ends of the signed range, unsigned overflow and the length limit.
    task automatic test_range_limits();
        send_text("9223372036854775807");
        send_text("9223372036854775808");
        send_text("-9223372036854775808");
        send_text("-9223372036854775809");
        send_text("18446744073709551615");
        send_text("18446744073709551616");
        send_text("+1234567890123456789");
        send_text("123456789012345678901");
    endtask

    // Leading zeros, misplaced signs, foreign bytes and string ends carried
    // by a no-character transfer.
    task automatic test_malformed();
        send_text("007");
        send_text("1-2");
        send_text("-+5");
        str_buf.delete();
        str_buf.push_back(8'hFF);
        str_buf.push_back(CH_ZERO + 8'd1);
        send_string(1'b0);
        str_buf.delete();
        str_buf.push_back(CH_ZERO + 8'd5);
        str_buf.push_back(8'h00);
        send_string(1'b0);
        // A filler transfer in the middle of a string changes nothing.
        send_item(CH_ZERO + 8'd4, 1'b0, 1'b0);
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(CH_ZERO + 8'd2, 1'b0, 1'b1);
        strings_sent = strings_sent + 1;
        str_buf.delete();
        str_buf.push_back(CH_MINUS);
        str_buf.push_back(CH_ZERO + 8'd8);
        send_string(1'b1);
        wait_results_drained();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // short strings back to back, so the block backs up and drops tready.
    task automatic test_backpressure();
        rx_hold_req = 200;
        tx_calm     = 1'b1;
        for (int i = 0; i < 12; i++) begin
            str_buf.delete();
            push_sign();
            push_digits($urandom_range(1, 3), 1'b1);
            send_string(1'b0);
        end
        tx_calm = 1'b0;
        wait_results_drained();
    endtask

    task automatic build_random_string();
        int kind;
        int pos;
        str_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            int nd;
            push_sign();
            nd = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 10);
            push_digits(nd, nd > 1);
        end else if (kind == 6) begin
            // Values that land at or around the signed or unsigned limit.
            string pre;
            push_sign();
            pre = $urandom_range(0, 1) ? "922337203685477580" : "1844674407370955161";
            for (int i = 0; i < pre.len(); i++)
                str_buf.push_back(pre[i]);
            push_digits(1, 1'b0);
        end else if (kind == 7) begin
            push_sign();
            push_digits($urandom_range(1, 8), 1'b1);
            pos = $urandom_range(0, str_buf.size() - 1);
            if ($urandom_range(0, 1))
                str_buf[pos] = 8'($urandom);
            else
                str_buf.insert(pos, 8'($urandom));
        end else if (kind == 8) begin
            int len;
            len = $urandom_range(0, 24);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 3))
                    0: str_buf.push_back(8'($urandom));
                    1: str_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    default: str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                endcase
            end
        end else begin
            if ($urandom_range(0, 1)) begin
                push_sign();
                str_buf.push_back(CH_ZERO);
                push_digits($urandom_range(0, 3), 1'b0);
            end else begin
                push_digits($urandom_range(21, 24), 1'b1);
            end
        end
    endtask

    // Mostly well-formed numbers with random content, the rest broken strings.
    // Idling on either side is switched off for some strings.
    task automatic test_random_strings();
        int target;
        target     = items_sent + RANDOM_ITEMS;
        noise_rate = 12;
        while (items_sent < target) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            build_random_string();
            send_string($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 39) == 0)
                wait_results_drained();
        end
        noise_rate = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
    endtask

    // Receiver: after each result transfer it draws a stall; a hold request
    // from a test overrides it with a long stretch.
    initial begin : result_receiver
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else if (m_ready && o_m_axis_tvalid) begin
                stall = rx_calm ? 0 : $urandom_range(0, 11);
            end else if (stall > 0) begin
                stall = stall - 1;
            end
            m_ready <= (stall == 0);
        end
    end

    // Every result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n && m_ready && o_m_axis_tvalid) begin
            if (pending_results.size() == 0) begin
                error_count = error_count + 1;
                $display("%0t: unexpected result, expected none, actual value %h ok %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (want.ok)
                    values_ok = values_ok + 1;
                else
                    values_refused = values_refused + 1;
                if (o_m_axis_tdata !== want.value) begin
                    error_count = error_count + 1;
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, want.value, o_m_axis_tdata);
                end
                if (o_m_axis_tuser !== want.ok) begin
                    error_count = error_count + 1;
                    $display("%0t: ok flag mismatch, expected %b, actual %b",
                             $time, want.ok, o_m_axis_tuser);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = 1'b0;
        s_last  = 1'b0;
        clear_parse_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_values();
        test_range_limits();
        test_malformed();
        test_backpressure();
        test_random_strings();
        wait_results_drained();

        $display("Parsed %0d strings over %0d character transfers.", strings_sent, items_sent);
        $display("Results: %0d valid values, %0d rejected strings.", values_ok, values_refused);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
